[sv/vwd_pkg.sv]
// Package for the vertex weld block: sizes, hash constants, slot layout, states and helpers.
package vwd_pkg;

    // Table size in slots; a power of two, so the home slot is the low hash bits.
    localparam int unsigned CAPACITY  = 4096;
    localparam int unsigned SLOT_W    = $clog2(CAPACITY);
    localparam int unsigned CNT_W     = SLOT_W + 1;
    localparam int unsigned COORD_W   = 32;
    localparam int unsigned SHIFT_W   = 5;
    localparam int unsigned OUT_IDX_W = 12;
    localparam int unsigned EPOCH_W   = 4;

    localparam logic [COORD_W-1:0] HASH_MUL_X = 32'd73856093;
    localparam logic [COORD_W-1:0] HASH_MUL_Y = 32'd19349663;
    localparam logic [COORD_W-1:0] HASH_MUL_Z = 32'd83492791;

    // One slot: epoch tag (zero is never live), quantized key and stored index.
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [COORD_W-1:0] key_x;
        logic [COORD_W-1:0] key_y;
        logic [COORD_W-1:0] key_z;
        logic [SLOT_W-1:0]  index;
    } slot_t;

    localparam int unsigned SLOT_BITS = $bits(slot_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MULT,
        ST_ISSUE,
        ST_PROBE,
        ST_HOLD
    } state_t;

    // Arithmetic right shift, floor toward minus infinity.
    function automatic logic [COORD_W-1:0] quantize(input logic [COORD_W-1:0] v,
                                                   input logic [SHIFT_W-1:0] sh);
        logic signed [COORD_W-1:0] s;
        s = $signed(v);
        return $unsigned(s >>> sh);
    endfunction

    // Fit a stored index to the result field: zero-extend or keep the low bits.
    function automatic logic [OUT_IDX_W-1:0] to_out_index(input logic [SLOT_W-1:0] i);
        logic [SLOT_W+OUT_IDX_W-1:0] wide;
        wide = {{OUT_IDX_W{1'b0}}, i};
        return wide[OUT_IDX_W-1:0];
    endfunction

endpackage

[sv/vertex_weld_dedup.sv]
// Vertex weld top level: quantize, hash, linear probe of the slot RAM, insert, hit or report full.
//
//  channel   signals                                       direction  transfer when
//  -------   -------------------------------------------   ---------  ---------------------
//  input     in_valid/in_ready, first_of_mesh, coord_x/y/z  in         in_valid & in_ready
//  result    out_valid/out_ready, vertex_index, is_new,     out        out_valid & out_ready
//            table_full
//  config    cfg_we, cfg_wdata (weld_shift)                 in         cfg_we
//
//  Flow: one vertex at a time; the probe makes one RAM read per cycle and visits from one
//  slot on a short chain up to CAPACITY slots when the table is full.
//  Reset: a clearing pass writes a dead tag to every slot, with in_ready low.
//  Mesh start: bumps the epoch tag; only when the tag wraps is the same pass run again.
//  Stalls: a result waiting on out_ready holds in an output register; the next vertex
//  is taken meanwhile, and the probe holds its result only if the register is still full.
module vertex_weld_dedup (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [vwd_pkg::SHIFT_W-1:0]      cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             first_of_mesh,
    input  logic [vwd_pkg::COORD_W-1:0]      coord_x,
    input  logic [vwd_pkg::COORD_W-1:0]      coord_y,
    input  logic [vwd_pkg::COORD_W-1:0]      coord_z,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [vwd_pkg::OUT_IDX_W-1:0]    vertex_index,
    output logic                             is_new,
    output logic                             table_full
);

    import vwd_pkg::*;

    // Control registers
    state_t               state_reg,     state_next;
    logic [SHIFT_W-1:0]   shift_reg,     shift_next;
    logic [EPOCH_W-1:0]   epoch_reg,     epoch_next;
    logic                 pend_reg,      pend_next;
    logic [SLOT_W-1:0]    clr_addr_reg,  clr_addr_next;
    logic [CNT_W-1:0]     count_reg,     count_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers
    logic [COORD_W-1:0]   q_x_reg, q_x_next, q_y_reg, q_y_next, q_z_reg, q_z_next;
    logic [COORD_W-1:0]   p_x_reg, p_x_next, p_y_reg, p_y_next, p_z_reg, p_z_next;
    logic [SLOT_W-1:0]    pos_reg,       pos_next;
    logic [SLOT_W-1:0]    probe_cnt_reg, probe_cnt_next;
    logic [OUT_IDX_W-1:0] out_idx_reg,   out_idx_next;
    logic                 out_new_reg,   out_new_next;
    logic                 out_full_reg,  out_full_next;
    logic [OUT_IDX_W-1:0] hold_idx_reg,  hold_idx_next;
    logic                 hold_new_reg,  hold_new_next;
    logic                 hold_full_reg, hold_full_next;

    // RAM port
    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [SLOT_W-1:0]    ram_raddr;
    slot_t                ram_wslot;
    logic [SLOT_BITS-1:0] ram_rdata;
    slot_t                rd_slot;

    // Probe decision
    logic [COORD_W-1:0]   hash_w;
    logic [SLOT_W-1:0]    home_slot;
    logic                 slot_live;
    logic                 key_hit;
    logic                 last_probe;
    logic                 probe_done;
    logic                 clr_last;
    logic                 epoch_max;
    logic                 in_xfer;
    logic                 out_free;
    logic [OUT_IDX_W-1:0] res_idx;
    logic                 res_new;
    logic                 res_full;

    vwd_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wslot),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_slot    = slot_t'(ram_rdata);
    assign hash_w     = p_x_reg ^ p_y_reg ^ p_z_reg;
    assign home_slot  = hash_w[SLOT_W-1:0];
    // A slot is live only when its tag matches the current mesh epoch.
    assign slot_live  = (rd_slot.tag == epoch_reg);
    assign key_hit    = (rd_slot.key_x == q_x_reg) && (rd_slot.key_y == q_y_reg) &&
                        (rd_slot.key_z == q_z_reg);
    assign last_probe = (probe_cnt_reg == SLOT_W'(CAPACITY - 1));
    assign probe_done = !slot_live || key_hit || last_probe;
    assign clr_last   = (clr_addr_reg == SLOT_W'(CAPACITY - 1));
    assign epoch_max  = &epoch_reg;
    assign in_xfer    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;

    // Result of the slot under inspection: free slot inserts, live match hits, else full.
    always_comb
    begin
        if (!slot_live)
        begin
            res_idx  = to_out_index(count_reg[SLOT_W-1:0]);
            res_new  = 1'b1;
            res_full = 1'b0;
        end
        else if (key_hit)
        begin
            res_idx  = to_out_index(rd_slot.index);
            res_new  = 1'b0;
            res_full = 1'b0;
        end
        else
        begin
            res_idx  = '0;
            res_new  = 1'b0;
            res_full = 1'b1;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = pend_reg ? ST_MULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (first_of_mesh && epoch_max) ? ST_CLEAR : ST_MULT;
                end
            end
            ST_MULT:  state_next = ST_ISSUE;
            ST_ISSUE: state_next = ST_PROBE;
            ST_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // FSM outputs: handshake and RAM port
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wslot = '0;
        ram_raddr = pos_reg + SLOT_W'(1);
        unique case (state_reg)
            ST_CLEAR:
            begin
                // Write a dead tag to every slot in turn.
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_ISSUE:
            begin
                ram_raddr = home_slot;
            end
            ST_PROBE:
            begin
                // Claim a free slot; the read of the next slot runs ahead anyway.
                ram_we          = !slot_live;
                ram_wslot.tag   = epoch_reg;
                ram_wslot.key_x = q_x_reg;
                ram_wslot.key_y = q_y_reg;
                ram_wslot.key_z = q_z_reg;
                ram_wslot.index = count_reg[SLOT_W-1:0];
            end
            ST_MULT, ST_HOLD:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath and counters
    always_comb
    begin
        shift_next     = cfg_we ? cfg_wdata : shift_reg;
        epoch_next     = epoch_reg;
        pend_next      = pend_reg;
        clr_addr_next  = clr_addr_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        q_x_next       = q_x_reg;
        q_y_next       = q_y_reg;
        q_z_next       = q_z_reg;
        p_x_next       = p_x_reg;
        p_y_next       = p_y_reg;
        p_z_next       = p_z_reg;
        pos_next       = pos_reg;
        probe_cnt_next = probe_cnt_reg;
        out_idx_next   = out_idx_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        hold_idx_next  = hold_idx_reg;
        hold_new_next  = hold_new_reg;
        hold_full_next = hold_full_reg;

        // Drop the shown result once it is taken.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + SLOT_W'(1);
                if (clr_last)
                begin
                    epoch_next = EPOCH_W'(1);
                    pend_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    q_x_next = quantize(coord_x, shift_reg);
                    q_y_next = quantize(coord_y, shift_reg);
                    q_z_next = quantize(coord_z, shift_reg);
                    if (first_of_mesh)
                    begin
                        count_next = '0;
                        if (epoch_max)
                        begin
                            pend_next     = 1'b1;
                            clr_addr_next = '0;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                end
            end
            ST_MULT:
            begin
                p_x_next = q_x_reg * HASH_MUL_X;
                p_y_next = q_y_reg * HASH_MUL_Y;
                p_z_next = q_z_reg * HASH_MUL_Z;
            end
            ST_ISSUE:
            begin
                pos_next       = home_slot;
                probe_cnt_next = '0;
            end
            ST_PROBE:
            begin
                if (!slot_live)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (probe_done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = res_idx;
                        out_new_next   = res_new;
                        out_full_next  = res_full;
                    end
                    else
                    begin
                        hold_idx_next  = res_idx;
                        hold_new_next  = res_new;
                        hold_full_next = res_full;
                    end
                end
                else
                begin
                    pos_next       = pos_reg + SLOT_W'(1);
                    probe_cnt_next = probe_cnt_reg + SLOT_W'(1);
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = hold_idx_reg;
                    out_new_next   = hold_new_reg;
                    out_full_next  = hold_full_reg;
                end
            end
            default:
            begin
                pend_next = pend_reg;
            end
        endcase
    end

    // Control state: cleared by reset; the slot RAM is swept from the clearing state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            shift_reg     <= '0;
            epoch_reg     <= '0;
            pend_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            epoch_reg     <= epoch_next;
            pend_reg      <= pend_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        q_x_reg       <= q_x_next;
        q_y_reg       <= q_y_next;
        q_z_reg       <= q_z_next;
        p_x_reg       <= p_x_next;
        p_y_reg       <= p_y_next;
        p_z_reg       <= p_z_next;
        pos_reg       <= pos_next;
        probe_cnt_reg <= probe_cnt_next;
        out_idx_reg   <= out_idx_next;
        out_new_reg   <= out_new_next;
        out_full_reg  <= out_full_next;
        hold_idx_reg  <= hold_idx_next;
        hold_new_reg  <= hold_new_next;
        hold_full_reg <= hold_full_next;
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_idx_reg;
    assign is_new       = out_new_reg;
    assign table_full   = out_full_reg;

`ifndef ASSERT_OFF
    // The stored vertex count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("vertex count beyond table size");

    // Every insert advances the vertex count by exactly one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && !slot_live) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert without count advance");

    // A finished clearing pass restarts the epoch at one.
    a_clear_epoch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && clr_last) |=> epoch_reg == EPOCH_W'(1))
        else $error("epoch not restarted after clearing pass");

    // A result is never both new and table full.
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && table_full))
        else $error("result flagged new and full");
`endif

endmodule

[sv/vwd_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
module vwd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
